>>> hdl/gdo_pkg.sv
package gdo_pkg;

   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned DAY_W   = 5;
   localparam int unsigned COUNT_W = 16;

   localparam logic [YEAR_W-1:0]  YEAR_MIN  = 14'd1;
   localparam logic [YEAR_W-1:0]  YEAR_MAX  = 14'd9999;
   localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
   localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
   localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]   DAY_DEC   = 5'd31;

   // reciprocal of 100 for a 14-bit year: q = (y * 1311) >> 17, never low,
   // exact for every multiple of four up to 9999
   localparam logic [10:0] RECIP_100 = 11'd1311;
   localparam int unsigned RECIP_SHIFT = 17;
   localparam int unsigned PROD_W = 25;
   localparam int unsigned QUOT_W = 8;
   localparam int unsigned REM_W  = 8;

   // last settle count, giving the leap pipeline time to follow a new year
   localparam logic [1:0] SETTLE_LAST = 2'd2;

   typedef struct packed {
      logic               action;
      logic [YEAR_W-1:0]  start_year;
      logic [MONTH_W-1:0] start_month;
      logic [DAY_W-1:0]   start_day;
      logic [COUNT_W-1:0] day_count;
   } req_type;

   typedef struct packed {
      logic [YEAR_W-1:0]  result_year;
      logic [MONTH_W-1:0] result_month;
      logic [DAY_W-1:0]   result_day;
      logic               year_out_of_range;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_SETTLE,
      ST_CLAMP,
      ST_STEP,
      ST_DONE
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;
      logic clamp;
      logic step;
      logic mark;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic count_zero;
      logic at_limit;
   } status_type;

   // month length, month 1..12
   function automatic logic [DAY_W-1:0] days_in(input logic [MONTH_W-1:0] month,
                                               input logic leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd2:                 len = leap ? 5'd29 : 5'd28;
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         default:              len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

>>> hdl/gregorian_date_offset.sv
// from start to rsp_strobe the date is walked day by day, ending early when the walk stops
// at the edge of the year range; one date at a time, the step counter moving one day per
// cycle once the leap pipeline has followed the loaded year
// busy stays high from acceptance until the result beat; rsp_strobe is a single cycle
// and the receiver cannot stall it
// synchronous active-high reset returns the controller to idle with no beat pending
module gregorian_date_offset (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  gdo_pkg::req_type req_item,
   output logic             busy,
   output logic             rsp_strobe,
   output gdo_pkg::rsp_type rsp_item
);

   gdo_pkg::cmd_type    cmd;
   gdo_pkg::status_type status;
   logic                done;
   logic                rsp_strobe_ff;

   gdo_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy),
      .done   (done)
   );

   gdo_dpath u_dpath (
      .clock  (clock),
      .req    (req_item),
      .cmd    (cmd),
      .status (status),
      .rsp    (rsp_item)
   );

   // result beat strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= done;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;

   // a result beat is never repeated in the next cycle
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("result strobe held for two cycles");

   // an accepted request makes the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted but block not busy");

   // the result beat comes only after the block has gone idle
   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result beat while still busy");

   // a boundary flag comes with a boundary date
   a_flag_date: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.year_out_of_range) |->
         ((rsp_item.result_year == 14'd9999 && rsp_item.result_month == 4'd12
           && rsp_item.result_day == 5'd31)
          || (rsp_item.result_year == 14'd1 && rsp_item.result_month == 4'd1
           && rsp_item.result_day == 5'd1)))
      else $error("range flag without boundary date");

   // the month of a result is always legal
   a_month_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.result_month >= 4'd1 && rsp_item.result_month <= 4'd12))
      else $error("result month out of range");

endmodule

>>> hdl/gdo_ctrl.sv
module gdo_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  gdo_pkg::status_type status,
   output gdo_pkg::cmd_type    cmd,
   output logic                busy,
   output logic                done
);

   gdo_pkg::state_type state_ff, state_in;
   logic [1:0]         settle_ff, settle_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= gdo_pkg::ST_IDLE;
         settle_ff <= 2'd0;
      end else begin
         state_ff  <= state_in;
         settle_ff <= settle_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      settle_in = settle_ff;
      cmd       = '0;
      done      = 1'b0;
      case (state_ff)
         gdo_pkg::ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = gdo_pkg::ST_LOAD;
            end
         end
         gdo_pkg::ST_LOAD: begin
            settle_in = 2'd0;
            state_in  = gdo_pkg::ST_SETTLE;
         end
         gdo_pkg::ST_SETTLE: begin
            settle_in = settle_ff + 2'd1;
            if (settle_ff == gdo_pkg::SETTLE_LAST) begin
               state_in = gdo_pkg::ST_CLAMP;
            end
         end
         gdo_pkg::ST_CLAMP: begin
            cmd.clamp = 1'b1;
            state_in  = gdo_pkg::ST_STEP;
         end
         gdo_pkg::ST_STEP: begin
            if (status.count_zero) begin
               state_in = gdo_pkg::ST_DONE;
            end else if (status.at_limit) begin
               cmd.mark = 1'b1;
               state_in = gdo_pkg::ST_DONE;
            end else begin
               cmd.step = 1'b1;
            end
         end
         gdo_pkg::ST_DONE: begin
            done     = 1'b1;
            state_in = gdo_pkg::ST_IDLE;
         end
         default: begin
            state_in = gdo_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy = (state_ff != gdo_pkg::ST_IDLE);

endmodule

>>> hdl/gdo_dpath.sv
module gdo_dpath (
   input  logic                clock,
   input  gdo_pkg::req_type    req,
   input  gdo_pkg::cmd_type    cmd,
   output gdo_pkg::status_type status,
   output gdo_pkg::rsp_type    rsp
);

   logic [gdo_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [gdo_pkg::MONTH_W-1:0] month_ff, month_in;
   logic [gdo_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [gdo_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        dir_ff, dir_in;
   logic                        flag_ff, flag_in;

   logic [gdo_pkg::PROD_W-1:0]  prod_ff;
   logic [gdo_pkg::YEAR_W-1:0]  year_a_ff;
   logic [gdo_pkg::REM_W-1:0]   rem_ff;
   logic [1:0]                  quot_lo_ff;
   logic                        div4_ff;
   logic                        leap_ff;

   logic [gdo_pkg::QUOT_W-1:0]  quot;
   logic [gdo_pkg::YEAR_W-1:0]  quot_x100;
   logic [gdo_pkg::YEAR_W-1:0]  rem_wide;
   logic                        rem_zero;
   logic [1:0]                  quot_lo;
   logic [gdo_pkg::DAY_W-1:0]   dim;
   logic [gdo_pkg::DAY_W-1:0]   dim_prev;
   logic [gdo_pkg::MONTH_W-1:0] month_prev;

   // leap stage one: multiply by reciprocal of 100
   always_ff @(posedge clock) begin
      prod_ff   <= gdo_pkg::PROD_W'(year_ff) * gdo_pkg::PROD_W'(gdo_pkg::RECIP_100);
      year_a_ff <= year_ff;
   end

   // leap stage two: remainder, only meaningful for multiples of four
   assign quot      = gdo_pkg::QUOT_W'(prod_ff >> gdo_pkg::RECIP_SHIFT);
   assign quot_x100 = (gdo_pkg::YEAR_W'(quot) << 6) + (gdo_pkg::YEAR_W'(quot) << 5)
                    + (gdo_pkg::YEAR_W'(quot) << 2);
   assign rem_wide  = year_a_ff - quot_x100;

   always_ff @(posedge clock) begin
      rem_ff     <= gdo_pkg::REM_W'(rem_wide);
      quot_lo_ff <= quot[1:0];
      div4_ff    <= (year_a_ff[1:0] == 2'd0);
   end

   // leap stage three: gregorian rule
   assign rem_zero = (rem_ff == 8'd0) || (rem_ff == 8'd100);
   assign quot_lo  = quot_lo_ff + {1'b0, (rem_ff >= 8'd100)};

   always_ff @(posedge clock) begin
      leap_ff <= div4_ff && (!rem_zero || (quot_lo == 2'd0));
   end

   // month lengths for the current and the previous month
   assign dim        = gdo_pkg::days_in(month_ff, leap_ff);
   assign month_prev = month_ff - 4'd1;
   assign dim_prev   = gdo_pkg::days_in(month_prev, leap_ff);

   // status toward the controller
   assign status.count_zero = (count_ff == '0);
   assign status.at_limit   = dir_ff
      ? (day_ff == gdo_pkg::DAY_FIRST && month_ff == gdo_pkg::MONTH_JAN
         && year_ff == gdo_pkg::YEAR_MIN)
      : (day_ff == dim && month_ff == gdo_pkg::MONTH_DEC && year_ff == gdo_pkg::YEAR_MAX);

   // date walk
   always_comb begin
      year_in  = year_ff;
      month_in = month_ff;
      day_in   = day_ff;
      count_in = count_ff;
      dir_in   = dir_ff;
      flag_in  = flag_ff;
      if (cmd.load) begin
         dir_in   = req.action;
         count_in = req.day_count;
         flag_in  = 1'b0;
         year_in  = req.start_year;
         if (req.start_year < gdo_pkg::YEAR_MIN) begin
            year_in = gdo_pkg::YEAR_MIN;
         end else if (req.start_year > gdo_pkg::YEAR_MAX) begin
            year_in = gdo_pkg::YEAR_MAX;
         end
         month_in = req.start_month;
         if (req.start_month < gdo_pkg::MONTH_JAN) begin
            month_in = gdo_pkg::MONTH_JAN;
         end else if (req.start_month > gdo_pkg::MONTH_DEC) begin
            month_in = gdo_pkg::MONTH_DEC;
         end
         day_in = (req.start_day == '0) ? gdo_pkg::DAY_FIRST : req.start_day;
      end else if (cmd.clamp) begin
         if (day_ff > dim) begin
            day_in = dim;
         end
      end else if (cmd.mark) begin
         flag_in = 1'b1;
      end else if (cmd.step) begin
         count_in = count_ff - 16'd1;
         if (!dir_ff) begin
            if (day_ff < dim) begin
               day_in = day_ff + 5'd1;
            end else if (month_ff < gdo_pkg::MONTH_DEC) begin
               month_in = month_ff + 4'd1;
               day_in   = gdo_pkg::DAY_FIRST;
            end else begin
               year_in  = year_ff + 14'd1;
               month_in = gdo_pkg::MONTH_JAN;
               day_in   = gdo_pkg::DAY_FIRST;
            end
         end else begin
            if (day_ff > gdo_pkg::DAY_FIRST) begin
               day_in = day_ff - 5'd1;
            end else if (month_ff > gdo_pkg::MONTH_JAN) begin
               month_in = month_prev;
               day_in   = dim_prev;
            end else begin
               year_in  = year_ff - 14'd1;
               month_in = gdo_pkg::MONTH_DEC;
               day_in   = gdo_pkg::DAY_DEC;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      year_ff  <= year_in;
      month_ff <= month_in;
      day_ff   <= day_in;
      count_ff <= count_in;
      dir_ff   <= dir_in;
      flag_ff  <= flag_in;
   end

   // result beat fields
   assign rsp.result_year       = year_ff;
   assign rsp.result_month      = month_ff;
   assign rsp.result_day        = day_ff;
   assign rsp.year_out_of_range = flag_ff;

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

   // direction codes carried in the action field
   localparam logic ACT_LATER   = 1'b0;
   localparam logic ACT_EARLIER = 1'b1;

   typedef struct {
      gdo_pkg::req_type item;
      int               gap;
      bit               drain_first;
   } date_job_type;

   logic             clock;
   logic             reset;
   logic             start = 1'b0;
   gdo_pkg::req_type req_item = '0;
   logic             busy;
   logic             rsp_strobe;
   gdo_pkg::rsp_type rsp_item;

   date_job_type     pending_dates[$];
   gdo_pkg::rsp_type expected_dates[$];
   logic             req_accepted;
   int               gap_left = 0;
   int               failures = 0;

   gregorian_date_offset u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_item   (req_item),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   // 20 ns clock
   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // month length with the gregorian leap rule
   function automatic int month_days(input int year, input int month);
      int lens[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
      bit leap;
      leap = ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
      if (month == 2 && leap) return 29;
      return lens[month - 1];
   endfunction

   // clamp the start date, then walk one day at a time
   function automatic gdo_pkg::rsp_type offset_date(input gdo_pkg::req_type r);
      int               y;
      int               m;
      int               d;
      int               n;
      bit               hit_edge;
      gdo_pkg::rsp_type res;
      y = int'(r.start_year);
      m = int'(r.start_month);
      d = int'(r.start_day);
      n = int'(r.day_count);
      hit_edge = 1'b0;
      if (y < 1) y = 1;
      if (y > 9999) y = 9999;
      if (m < 1) m = 1;
      if (m > 12) m = 12;
      if (d < 1) d = 1;
      if (d > month_days(y, m)) d = month_days(y, m);
      while (n > 0 && !hit_edge) begin
         if (r.action == ACT_LATER) begin
            if (d < month_days(y, m)) d++;
            else if (m < 12) begin
               m++;
               d = 1;
            end else if (y < 9999) begin
               y++;
               m = 1;
               d = 1;
            end else hit_edge = 1'b1;
         end else begin
            if (d > 1) d--;
            else if (m > 1) begin
               m--;
               d = month_days(y, m);
            end else if (y > 1) begin
               y--;
               m = 12;
               d = 31;
            end else hit_edge = 1'b1;
         end
         if (!hit_edge) n--;
      end
      res.result_year       = y[gdo_pkg::YEAR_W-1:0];
      res.result_month      = m[gdo_pkg::MONTH_W-1:0];
      res.result_day        = d[gdo_pkg::DAY_W-1:0];
      res.year_out_of_range = hit_edge;
      return res;
   endfunction

   // mostly back to back, sometimes short gaps, rarely long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(20, 150);
   endfunction

   task automatic add_date(input logic act, input logic [gdo_pkg::YEAR_W-1:0] y,
                           input logic [gdo_pkg::MONTH_W-1:0] m,
                           input logic [gdo_pkg::DAY_W-1:0] d,
                           input logic [gdo_pkg::COUNT_W-1:0] n, input bit drain,
                           input int gap);
      date_job_type job;
      job.item.action      = act;
      job.item.start_year  = y;
      job.item.start_month = m;
      job.item.start_day   = d;
      job.item.day_count   = n;
      job.gap              = gap;
      job.drain_first      = drain;
      pending_dates.push_back(job);
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $error("%s mismatch: expected %0d, actual %0d", name, want, got);
         failures++;
      end
   endtask

   // driver: present one beat at a time, hold start until it is taken
   always @(negedge clock) begin
      logic         next_start;
      date_job_type job;
      next_start = start;
      if (!reset && (!start || req_accepted)) begin
         next_start = 1'b0;
         if (gap_left > 0) gap_left--;
         else if (pending_dates.size() != 0 &&
                  (!pending_dates[0].drain_first ||
                   (expected_dates.size() == 0 && !busy))) begin
            job = pending_dates.pop_front();
            req_item  <= job.item;
            next_start = 1'b1;
            gap_left   = job.gap;
         end
      end
      start <= next_start;
   end

   // monitor: record accepted beats, check result beats
   always @(posedge clock) begin
      gdo_pkg::rsp_type want;
      if (reset) req_accepted <= 1'b0;
      else begin
         if (rsp_strobe) begin
            if (expected_dates.size() == 0) begin
               $error("result beat with no date outstanding");
               failures++;
            end else begin
               want = expected_dates.pop_front();
               compare_field("result_year", int'(want.result_year),
                             int'(rsp_item.result_year));
               compare_field("result_month", int'(want.result_month),
                             int'(rsp_item.result_month));
               compare_field("result_day", int'(want.result_day),
                             int'(rsp_item.result_day));
               compare_field("year_out_of_range", int'(want.year_out_of_range),
                             int'(rsp_item.year_out_of_range));
            end
         end
         if (start && !busy) expected_dates.push_back(offset_date(req_item));
         req_accepted <= start && !busy;
      end
   end

   // stimulus, reset and end of run
   initial begin
      int                              k;
      int                              sel;
      logic                            act;
      logic [gdo_pkg::YEAR_W-1:0]      y;
      logic [gdo_pkg::MONTH_W-1:0]     m;
      logic [gdo_pkg::DAY_W-1:0]       d;
      logic [gdo_pkg::COUNT_W-1:0]     n;
      reset = 1'b1;

      // directed: zero count, rollovers, leap rule, clamping, edges of the range
      add_date(ACT_LATER,   2023, 6, 15, 0, 0, pick_gap());
      add_date(ACT_EARLIER, 2023, 6, 15, 0, 0, pick_gap());
      add_date(ACT_LATER,   2023, 12, 31, 1, 0, pick_gap());
      add_date(ACT_EARLIER, 2024, 1, 1, 1, 0, pick_gap());
      add_date(ACT_LATER,   2024, 2, 28, 1, 0, pick_gap());
      add_date(ACT_LATER,   1900, 2, 28, 1, 0, pick_gap());
      add_date(ACT_LATER,   2000, 2, 28, 2, 0, pick_gap());
      add_date(ACT_EARLIER, 2100, 3, 1, 1, 0, pick_gap());
      add_date(ACT_EARLIER, 2000, 3, 1, 1, 0, pick_gap());
      add_date(ACT_LATER,   0, 5, 10, 3, 0, pick_gap());
      add_date(ACT_LATER,   14'h3FFF, 5, 10, 0, 0, pick_gap());
      add_date(ACT_LATER,   2022, 0, 20, 0, 0, pick_gap());
      add_date(ACT_EARLIER, 2022, 15, 20, 0, 0, pick_gap());
      add_date(ACT_LATER,   2022, 4, 0, 0, 0, pick_gap());
      add_date(ACT_LATER,   2023, 2, 31, 0, 0, pick_gap());
      add_date(ACT_LATER,   2024, 2, 31, 1, 0, pick_gap());
      add_date(ACT_LATER,   2022, 4, 31, 0, 0, pick_gap());
      add_date(ACT_LATER,   9999, 12, 30, 5, 0, pick_gap());
      add_date(ACT_EARLIER, 1, 1, 2, 10, 0, pick_gap());
      add_date(ACT_LATER,   1, 1, 1, 16'hFFFF, 0, pick_gap());
      add_date(ACT_EARLIER, 14'h3FFF, 4'hF, 5'h1F, 16'hFFFF, 0, pick_gap());
      add_date(ACT_LATER,   0, 0, 0, 0, 1, pick_gap());
      add_date(ACT_LATER,   9900, 1, 1, 16'hFFFF, 0, pick_gap());
      add_date(ACT_EARLIER, 1, 1, 1, 1, 0, pick_gap());
      add_date(ACT_LATER,   9999, 12, 31, 0, 0, pick_gap());

      // random: mostly valid dates, some raw field noise, few long walks
      for (k = 0; k < 75; k++) begin
         act = 1'($urandom_range(0, 1));
         sel = $urandom_range(0, 99);
         if (sel < 80) begin
            sel = $urandom_range(0, 9);
            if (sel < 2) y = gdo_pkg::YEAR_W'($urandom_range(1, 400));
            else if (sel < 4) y = gdo_pkg::YEAR_W'($urandom_range(9600, 9999));
            else y = gdo_pkg::YEAR_W'($urandom_range(1, 9999));
            m = gdo_pkg::MONTH_W'($urandom_range(1, 12));
            d = gdo_pkg::DAY_W'($urandom_range(1, month_days(int'(y), int'(m))));
         end else begin
            y = gdo_pkg::YEAR_W'($urandom_range(0, 16383));
            m = gdo_pkg::MONTH_W'($urandom_range(0, 15));
            d = gdo_pkg::DAY_W'($urandom_range(0, 31));
         end
         sel = $urandom_range(0, 99);
         if (sel < 5) n = '0;
         else if (sel < 92) n = gdo_pkg::COUNT_W'($urandom_range(1, 800));
         else n = gdo_pkg::COUNT_W'($urandom_range(0, 65535));
         // a stretch with no gaps between requests in the middle
         add_date(act, y, m, d, n, ($urandom_range(0, 19) == 0),
                  (k >= 30 && k < 50) ? 0 : pick_gap());
      end

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_dates.size() != 0 || start) @(posedge clock);
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (failures == 0) $display("gregorian_date_offset verification clean");
      else $display("gregorian_date_offset verification failed");
      $finish;
   end

   // watchdog
   initial begin
      #600ms;
      $display("gregorian_date_offset verification failed");
      $finish;
   end

endmodule
